@@ hdl/dadd_pkg.sv @@
// ----------------------------------------------------------------------------
// dadd_pkg
// Shared widths, month table and helpers for the date adder.
// ----------------------------------------------------------------------------
package dadd_pkg;

   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 14;
   localparam int COUNT_W = 15;

   // running day total: a full year, a start day and the largest count fit
   localparam int TOTAL_W = 16;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   // floor(y / 100) as (y * DIV100_MUL) >> DIV100_SHIFT, exact for 14-bit y
   localparam int DIV100_MUL   = 5243;
   localparam int DIV100_SHIFT = 19;
   localparam int MUL_W        = YEAR_W + 13;
   localparam int CENT_W       = MUL_W - DIV100_SHIFT;

   localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
      5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
   };

   typedef struct packed {
      logic [DAY_W-1:0]   start_day;
      logic [MONTH_W-1:0] start_month;
      logic [YEAR_W-1:0]  start_year;
      logic [COUNT_W-1:0] days_to_add;
   } req_beat_type;

   // length of month m in a year with the given leap flag; zero off the calendar
   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
      logic [MONTH_W-1:0] idx;
      idx = m - MONTH_JAN;
      if (m < MONTH_JAN || m > MONTH_DEC) begin
         return '0;
      end else if (m == MONTH_FEB) begin
         return leap ? 5'd29 : 5'd28;
      end else begin
         return MONTH_LEN[idx];
      end
   endfunction

endpackage

@@ hdl/dadd_ifs.sv @@
// ----------------------------------------------------------------------------
// dadd_ifs
// Valid/ready channels for the date adder: start date in, end date out.
// ----------------------------------------------------------------------------
interface dadd_req_if import dadd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [DAY_W-1:0]   start_day;
   logic [MONTH_W-1:0] start_month;
   logic [YEAR_W-1:0]  start_year;
   logic [COUNT_W-1:0] days_to_add;

   modport source (output valid, output start_day, output start_month,
                   output start_year, output days_to_add, input ready);
   modport sink   (input valid, input start_day, input start_month,
                   input start_year, input days_to_add, output ready);
endinterface

interface dadd_rsp_if import dadd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [DAY_W-1:0]   end_day;
   logic [MONTH_W-1:0] end_month;
   logic [YEAR_W-1:0]  end_year;

   modport source (output valid, output end_day, output end_month,
                   output end_year, input ready);
   modport sink   (input valid, input end_day, input end_month,
                   input end_year, output ready);
endinterface

@@ hdl/date_add_days_unit.sv @@
// ----------------------------------------------------------------------------
// date_add_days_unit
// Gregorian date plus a day count, walked one month per cycle apart from the leap decode at each year rollover.
// ----------------------------------------------------------------------------
//  channel | dir | fields                                          | handshake
//  req_bus | in  | start_day, start_month, start_year, days_to_add | valid/ready
//  rsp_bus | out | end_day, end_month, end_year                    | valid/ready
//
//  One beat at a time. An accepted beat runs the leap decode, sums the months
//  before the start month, then walks whole months off the running total and
//  reruns the leap decode at each year rollover; the walk is bound by the single
//  add/subtract unit on the running total. The result beat becomes valid in the
//  same cycle as the block is ready for the next accept. Reset
//  clears the sequencer and the result valid. A stalled result beat holds in
//  the output register; the walk waits at its last step until that register
//  is free.
// ----------------------------------------------------------------------------
module date_add_days_unit import dadd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   dadd_req_if.sink   req_bus,
   dadd_rsp_if.source rsp_bus
);

   // sequencer codes
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_LEAP1 = 3'd1;   // multiply year by the reciprocal of 100
   localparam logic [2:0] S_LEAP2 = 3'd2;   // remainder and leap flag
   localparam logic [2:0] S_SUM   = 3'd3;   // add lengths of months before the start
   localparam logic [2:0] S_WALK  = 3'd4;   // take off whole months

   logic [2:0]         state_ff, state_in;
   logic               walk_ff, walk_in;
   logic               leap_ff, leap_in;
   logic [MONTH_W-1:0] m_ff, m_in;
   logic [MONTH_W-1:0] month_ff, month_in;
   logic [YEAR_W-1:0]  year_ff, year_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [MUL_W-1:0]   prod_ff, prod_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [DAY_W-1:0]   end_day_ff, end_day_in;
   logic [MONTH_W-1:0] end_month_ff, end_month_in;
   logic [YEAR_W-1:0]  end_year_ff, end_year_in;

   req_beat_type       beat;
   logic               req_fire;
   logic               out_free;

   // shared add/subtract unit on the running total
   logic [DAY_W-1:0]   cur_len;
   logic               do_sub;
   logic [TOTAL_W:0]   alu;
   logic               total_gt;

   // leap decode
   logic [CENT_W-1:0]  cent;
   logic [YEAR_W-1:0]  cent_x100;
   logic [YEAR_W-1:0]  rem100;

   assign beat.start_day   = req_bus.start_day;
   assign beat.start_month = req_bus.start_month;
   assign beat.start_year  = req_bus.start_year;
   assign beat.days_to_add = req_bus.days_to_add;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;

   assign cur_len = month_days(m_ff, leap_ff);
   assign do_sub  = (state_ff == S_WALK);
   assign alu     = do_sub ? ({1'b0, total_ff} - {{(TOTAL_W-DAY_W+1){1'b0}}, cur_len})
                           : ({1'b0, total_ff} + {{(TOTAL_W-DAY_W+1){1'b0}}, cur_len});
   // total > len when the difference neither borrows nor is zero
   assign total_gt = !alu[TOTAL_W] && (alu[TOTAL_W-1:0] != '0);

   assign cent      = prod_ff[MUL_W-1:DIV100_SHIFT];
   assign cent_x100 = YEAR_W'({{(YEAR_W-CENT_W){1'b0}}, cent} * YEAR_W'(100));
   assign rem100    = year_ff - cent_x100;

   always_comb begin
      state_in     = state_ff;
      walk_in      = walk_ff;
      leap_in      = leap_ff;
      m_in         = m_ff;
      month_in     = month_ff;
      year_in      = year_ff;
      total_in     = total_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      end_day_in   = end_day_ff;
      end_month_in = end_month_ff;
      end_year_in  = end_year_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               // latch the beat; start day and count seed the total
               month_in = beat.start_month;
               year_in  = beat.start_year;
               total_in = TOTAL_W'(beat.start_day) + TOTAL_W'(beat.days_to_add);
               m_in     = MONTH_JAN;
               walk_in  = 1'b0;
               state_in = S_LEAP1;
            end
         end
         S_LEAP1: begin
            prod_in  = MUL_W'(year_ff) * MUL_W'(DIV100_MUL);
            state_in = S_LEAP2;
         end
         S_LEAP2: begin
            // leap when divisible by 4 and not by 100, or divisible by 400
            leap_in  = (year_ff[1:0] == 2'b00) &&
                       ((rem100 != '0) || (cent[1:0] == 2'b00));
            state_in = walk_ff ? S_WALK : S_SUM;
         end
         S_SUM: begin
            if (m_ff < month_ff) begin
               total_in = alu[TOTAL_W-1:0];
               m_in     = m_ff + MONTH_W'(1);
            end else begin
               m_in     = MONTH_JAN;
               walk_in  = 1'b1;
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            if (total_gt) begin
               total_in = alu[TOTAL_W-1:0];
               if (m_ff == MONTH_DEC) begin
                  // roll into January; the year counter steps on and wraps at its top, refresh leap
                  m_in     = MONTH_JAN;
                  year_in  = year_ff + YEAR_W'(1);
                  state_in = S_LEAP1;
               end else begin
                  m_in = m_ff + MONTH_W'(1);
               end
            end else if (out_free) begin
               // drop the result into the output register
               rsp_valid_in = 1'b1;
               end_day_in   = total_ff[DAY_W-1:0];
               end_month_in = m_ff;
               end_year_in  = year_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         walk_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         walk_ff      <= walk_in;
      end
   end

   always_ff @(posedge clock) begin
      leap_ff      <= leap_in;
      m_ff         <= m_in;
      month_ff     <= month_in;
      year_ff      <= year_in;
      total_ff     <= total_in;
      prod_ff      <= prod_in;
      end_day_ff   <= end_day_in;
      end_month_ff <= end_month_in;
      end_year_ff  <= end_year_in;
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.end_day   = end_day_ff;
   assign rsp_bus.end_month = end_month_ff;
   assign rsp_bus.end_year  = end_year_ff;

   // an accepted beat always starts with the leap decode
   a_accept_to_leap: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == S_LEAP1))
      else $error("accepted beat did not start leap decode");

   // the walk only visits calendar months
   a_walk_month: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> (m_ff >= MONTH_JAN && m_ff <= MONTH_DEC))
      else $error("walk month off the calendar");

   // a leap flag from the decode needs a year divisible by four
   a_leap_div4: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LEAP2) |=> (!leap_ff || (year_ff[1:0] == 2'b00)))
      else $error("leap flag on a year not divisible by four");

   // a pending result is never overwritten by the next one
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_bus.ready) |=> rsp_valid_ff)
      else $error("pending result dropped");

endmodule

@@ test/date_add_days_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_add_days_check
// Watches both channels of the date adder, works out each end date from the
// accepted start beat and compares it with the result beats in order.
// ----------------------------------------------------------------------------
module date_add_days_check import dadd_pkg::*; (
   input  logic clock,
   input  logic reset,
   dadd_req_if  req_bus,
   dadd_rsp_if  rsp_bus,
   output int   mismatch_count,
   output int   dates_due
);

   typedef struct packed {
      logic [DAY_W-1:0]   end_day;
      logic [MONTH_W-1:0] end_month;
      logic [YEAR_W-1:0]  end_year;
   } end_date_type;

   end_date_type due_dates [$];

   // 4/100/400 rule on the raw counter value; year 0 is a leap year
   function automatic logic is_leap_year(input logic [YEAR_W-1:0] y);
      int yi;
      yi = int'(y);
      return ((yi % 4 == 0) && (yi % 100 != 0)) || (yi % 400 == 0);
   endfunction

   function automatic logic [TOTAL_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                       input logic [YEAR_W-1:0] y);
      if (m < MONTH_JAN || m > MONTH_DEC) begin
         return '0;
      end
      if (m == MONTH_FEB) begin
         return is_leap_year(y) ? TOTAL_W'(29) : TOTAL_W'(28);
      end
      return TOTAL_W'(MONTH_LEN[m - MONTH_JAN]);
   endfunction

   function automatic end_date_type advance_date(input req_beat_type beat);
      logic [TOTAL_W-1:0] total;
      logic [MONTH_W-1:0] m;
      logic [YEAR_W-1:0]  yr;
      end_date_type       date;
      total = '0;
      yr    = beat.start_year;
      // day of the year: months before the start month, then the start day and the count
      for (m = MONTH_JAN; m < beat.start_month; m++) begin
         total += month_length(m, yr);
      end
      total += TOTAL_W'(beat.start_day) + TOTAL_W'(beat.days_to_add);
      // walk from January, rolling the 14-bit year after December
      m = MONTH_JAN;
      while (total > month_length(m, yr)) begin
         total -= month_length(m, yr);
         if (m == MONTH_DEC) begin
            m  = MONTH_JAN;
            yr = yr + YEAR_W'(1);
         end else begin
            m = m + MONTH_W'(1);
         end
      end
      date.end_day   = total[DAY_W-1:0];
      date.end_month = m;
      date.end_year  = yr;
      return date;
   endfunction

   always @(posedge clock) begin
      end_date_type seen;
      end_date_type want;
      req_beat_type beat;
      if (reset) begin
         mismatch_count = 0;
         dates_due      = 0;
         due_dates.delete();
      end else begin
         // check the result beat first so it cannot match a start beat of this edge
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen = '{rsp_bus.end_day, rsp_bus.end_month, rsp_bus.end_year};
            if (due_dates.size() == 0) begin
               $display("%0t: unexpected result %0d/%0d/%0d", $time,
                        seen.end_day, seen.end_month, seen.end_year);
               mismatch_count++;
            end else begin
               want = due_dates.pop_front();
               if (seen !== want) begin
                  $display("%0t: end date expected %0d/%0d/%0d actual %0d/%0d/%0d",
                           $time, want.end_day, want.end_month, want.end_year,
                           seen.end_day, seen.end_month, seen.end_year);
                  mismatch_count++;
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            beat = '{req_bus.start_day, req_bus.start_month,
                     req_bus.start_year, req_bus.days_to_add};
            due_dates.push_back(advance_date(beat));
         end
         dates_due = due_dates.size();
      end
   end

endmodule

@@ test/date_add_days_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_add_days_unit_test
// Drives start dates and day counts into the date adder with random gaps and
// result stalls, including one long result hold-off that backs up the input.
// The checker beside the block predicts every end date and counts mismatches.
// ----------------------------------------------------------------------------
module date_add_days_unit_test import dadd_pkg::*; ();

   // random beats after the corner list
   localparam int RANDOM_ITEMS   = 518;
   // hold the result side this long once, after this many results
   localparam int BACKLOG_AFTER  = 80;
   localparam int BACKLOG_HOLD   = 3000;
   // cycles without any beat before giving up; covers the hold-off plus the
   // slowest walk and the longest random stall
   localparam int WATCHDOG_LIMIT = 20000;
   // quiet time after the last result, one slow walk's worth
   localparam int DRAIN_CYCLES   = 1400;

   logic clock;
   logic reset;

   dadd_req_if req_bus ();
   dadd_rsp_if rsp_bus ();

   int mismatch_count;
   int dates_due;
   int results_taken;
   int idle_cycles;
   int quiet_sends;

   date_add_days_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   date_add_days_check date_check (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .mismatch_count (mismatch_count),
      .dates_due      (dates_due)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Gap length shared by both sides: mostly none or short, now and then long.
   function automatic int idle_length();
      int roll;
      roll = $urandom_range(99);
      if (roll < 60) begin
         return 0;
      end else if (roll < 90) begin
         return $urandom_range(1, 3);
      end else if (roll < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 80);
   endfunction

   // Offer one start beat at a falling edge and hold it until it is taken.
   // Leave valid high between back-to-back beats so it only gets one update
   // per edge.
   task automatic offer_date(input req_beat_type beat);
      int gap;
      if (quiet_sends > 0) begin
         gap = 0;
         quiet_sends--;
      end else begin
         if ($urandom_range(99) < 3) begin
            quiet_sends = $urandom_range(20, 50);
         end
         gap = idle_length();
      end
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.start_day   <= beat.start_day;
      req_bus.start_month <= beat.start_month;
      req_bus.start_year  <= beat.start_year;
      req_bus.days_to_add <= beat.days_to_add;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   // Count result beats and watch for a stuck channel.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles   <= 0;
         results_taken <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_taken <= results_taken + 1;
         end
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // Result side: random stalls, quiet stretches with ready held high, and one
   // long hold-off so the block fills and pushes back on the start channel.
   initial begin
      int  stall_left;
      int  quiet_left;
      int  stall;
      bit  backlog_done;
      stall_left   = 0;
      quiet_left   = 0;
      backlog_done = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!backlog_done && results_taken >= BACKLOG_AFTER) begin
            backlog_done = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (BACKLOG_HOLD) @(negedge clock);
         end
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else if (quiet_left > 0) begin
            rsp_bus.ready <= 1'b1;
            quiet_left--;
         end else if ($urandom_range(99) < 3) begin
            quiet_left = $urandom_range(20, 60);
            rsp_bus.ready <= 1'b1;
         end else begin
            stall = idle_length();
            if (stall > 0) begin
               stall_left = stall - 1;
               rsp_bus.ready <= 1'b0;
            end else begin
               rsp_bus.ready <= 1'b1;
            end
         end
      end
   end

   // Start side and verdict.
   initial begin
      req_beat_type corner_dates [$];
      req_beat_type beat;
      int           roll;
      reset               = 1'b1;
      quiet_sends         = 0;
      req_bus.valid       = 1'b0;
      req_bus.start_day   = '0;
      req_bus.start_month = '0;
      req_bus.start_year  = '0;
      req_bus.days_to_add = '0;

      // plain dates and leap rules
      corner_dates.push_back('{5'd1,  4'd1,  14'd1,     15'd0});
      corner_dates.push_back('{5'd31, 4'd12, 14'd9999,  15'd1});
      corner_dates.push_back('{5'd28, 4'd2,  14'd2000,  15'd1});
      corner_dates.push_back('{5'd28, 4'd2,  14'd1900,  15'd1});
      corner_dates.push_back('{5'd28, 4'd2,  14'd2024,  15'd1});
      corner_dates.push_back('{5'd28, 4'd2,  14'd2023,  15'd2});
      corner_dates.push_back('{5'd1,  4'd3,  14'd2100,  15'd365});
      corner_dates.push_back('{5'd29, 4'd2,  14'd2400,  15'd366});
      corner_dates.push_back('{5'd30, 4'd11, 14'd1600,  15'd31});
      corner_dates.push_back('{5'd15, 4'd6,  14'd1234,  15'd12345});
      // day zero with nothing added lands on day 0 of January
      corner_dates.push_back('{5'd0,  4'd1,  14'd2020,  15'd0});
      corner_dates.push_back('{5'd0,  4'd0,  14'd0,     15'd0});
      // month zero sums no earlier months
      corner_dates.push_back('{5'd0,  4'd0,  14'd500,   15'd5});
      corner_dates.push_back('{5'd15, 4'd0,  14'd1999,  15'd20});
      // months past December add a whole year
      corner_dates.push_back('{5'd10, 4'd13, 14'd2001,  15'd0});
      corner_dates.push_back('{5'd31, 4'd14, 14'd2004,  15'd5});
      // start day past the end of its month carries forward
      corner_dates.push_back('{5'd31, 4'd2,  14'd2021,  15'd0});
      corner_dates.push_back('{5'd31, 4'd4,  14'd2022,  15'd3});
      // year counter wraps to 0, which is a leap year
      corner_dates.push_back('{5'd31, 4'd12, 14'd16383, 15'd1});
      corner_dates.push_back('{5'd1,  4'd1,  14'd0,     15'd59});
      corner_dates.push_back('{5'd1,  4'd1,  14'd16383, 15'd32767});
      corner_dates.push_back('{5'd31, 4'd15, 14'd16383, 15'd32767});

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (corner_dates[i]) begin
         offer_date(corner_dates[i]);
      end

      repeat (RANDOM_ITEMS) begin
         // mostly real calendar dates, the rest anything the fields can hold
         if ($urandom_range(99) < 85) begin
            beat.start_month = MONTH_W'($urandom_range(1, 12));
            beat.start_year  = YEAR_W'($urandom_range(1, 9999));
            if ($urandom_range(99) < 85) begin
               beat.start_day = DAY_W'($urandom_range(1, 28));
            end else begin
               beat.start_day = DAY_W'($urandom_range(29, 31));
            end
         end else begin
            beat.start_day   = DAY_W'($urandom_range(0, 31));
            beat.start_month = MONTH_W'($urandom_range(0, 15));
            if ($urandom_range(2) == 0) begin
               beat.start_year = 14'd16383 - 14'($urandom_range(0, 100));
            end else begin
               beat.start_year = YEAR_W'($urandom_range(0, 16383));
            end
         end
         // keep most walks short; a few go the full count range
         roll = $urandom_range(99);
         if (roll < 60) begin
            beat.days_to_add = COUNT_W'($urandom_range(0, 400));
         end else if (roll < 85) begin
            beat.days_to_add = COUNT_W'($urandom_range(0, 4000));
         end else begin
            beat.days_to_add = COUNT_W'($urandom_range(0, 32767));
         end
         offer_date(beat);
      end
      req_bus.valid <= 1'b0;

      // drain, then give a stray result time to show up
      while (dates_due != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
